// ===== sv/sbe_pkg.sv =====
// ----------------------------------------------------------------------------
// sbe_pkg: shared definitions for the stack bytecode executor
// Opcodes, fault codes, and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package sbe_pkg;

  localparam int STACK_BYTES_DEF = 4096;
  localparam int OP_W   = 16;
  localparam int IMM_W  = 48;
  localparam int WORD_W = 64;
  localparam int FLT_W  = 3;

  localparam logic [OP_W-1:0] OP_NOP   = 16'd0;
  localparam logic [OP_W-1:0] OP_CALL  = 16'd1;
  localparam logic [OP_W-1:0] OP_RET   = 16'd2;
  localparam logic [OP_W-1:0] OP_PUSH  = 16'd3;
  localparam logic [OP_W-1:0] OP_LOAD  = 16'd4;
  localparam logic [OP_W-1:0] OP_FLOAD = 16'd5;
  localparam logic [OP_W-1:0] OP_JUMP  = 16'd6;
  localparam logic [OP_W-1:0] OP_BRT   = 16'd7;
  localparam logic [OP_W-1:0] OP_BRF   = 16'd8;
  localparam logic [OP_W-1:0] OP_ADD   = 16'd9;
  localparam logic [OP_W-1:0] OP_SUB   = 16'd10;
  localparam logic [OP_W-1:0] OP_MUL   = 16'd11;
  localparam logic [OP_W-1:0] OP_DIV   = 16'd12;
  localparam logic [OP_W-1:0] OP_MOD   = 16'd13;
  localparam logic [OP_W-1:0] OP_EQ    = 16'd14;
  localparam logic [OP_W-1:0] OP_NE    = 16'd15;
  localparam logic [OP_W-1:0] OP_LT    = 16'd16;
  localparam logic [OP_W-1:0] OP_LE    = 16'd17;
  localparam logic [OP_W-1:0] OP_GT    = 16'd18;
  localparam logic [OP_W-1:0] OP_GE    = 16'd19;
  localparam logic [OP_W-1:0] OP_ITOF  = 16'd20;
  localparam logic [OP_W-1:0] OP_FTOI  = 16'd21;
  localparam logic [OP_W-1:0] OP_EXIT  = 16'd22;

  typedef enum logic [FLT_W-1:0] {
    FLT_NONE  = 3'd0,
    FLT_OVER  = 3'd1,
    FLT_UNDER = 3'd2,
    FLT_RANGE = 3'd3,
    FLT_DIV0  = 3'd4
  } fault_t;

  typedef enum logic [2:0] {
    ADR_SP, ADR_SP8, ADR_SPM8, ADR_SPM16, ADR_BPM8, ADR_BPM16, ADR_LOAD, ADR_RET
  } adr_t;

  typedef enum logic [2:0] {
    WD_IP, WD_BP, WD_IMM, WD_A, WD_ALU, WD_UNIT, WD_FTOI
  } wd_t;

  typedef enum logic [2:0] {
    ALU_ADD, ALU_SUB, ALU_EQ, ALU_NE, ALU_LT, ALU_LE, ALU_GT, ALU_GE
  } alu_t;

  typedef enum logic [1:0] {UNIT_MUL, UNIT_DIV, UNIT_MOD, UNIT_ITOF} unit_t;

  typedef enum logic [2:0] {SP_KEEP, SP_INC8, SP_INC16, SP_DEC8, SP_RET} sp_op_t;
  typedef enum logic [1:0] {BP_KEEP, BP_CALL, BP_RESTORE} bp_op_t;
  typedef enum logic [1:0] {IP_KEEP, IP_INC, IP_IMM, IP_RET} ip_op_t;

  typedef struct packed {
    logic   take;
    logic   clr;
    logic   rd_en;
    adr_t   rd_adr;
    logic   cap_a;
    logic   cap_b;
    logic   cap_c;
    logic   wr_en;
    adr_t   wr_adr;
    wd_t    wr_dat;
    alu_t   alu;
    logic   frame_rel;
    logic   unit_go;
    unit_t  unit_op;
    sp_op_t sp_op;
    bp_op_t bp_op;
    ip_op_t ip_op;
    fault_t fault;
    logic   halt_set;
    logic   exit_set;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic halted;
    logic sp_lt8;
    logic sp_lt16;
    logic room8;
    logic room16;
    logic bp_lt16;
    logic ld_bad;
    logic imm_gt_base;
    logic nbp_big;
    logic a_nz;
    logic b_zero;
    logic unit_done;
  } sts_t;

endpackage

// ===== sv/sbe_stack.sv =====
// ----------------------------------------------------------------------------
// sbe_stack: byte-addressed stack memory
// Eight byte banks so one unaligned 64-bit word is read or written per cycle.
// ----------------------------------------------------------------------------
module sbe_stack import sbe_pkg::*; #(
  parameter  int STACK_BYTES = STACK_BYTES_DEF,
  localparam int PW   = $clog2(STACK_BYTES + 1),
  localparam int ROWS = (STACK_BYTES + 7) / 8,
  localparam int RW   = $clog2(ROWS)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [PW-1:0]     rd_addr,
  input  logic              wr_en,
  input  logic [PW-1:0]     wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic              clr_en,
  input  logic [RW-1:0]     clr_row,
  output logic [WORD_W-1:0] rd_data
);

  logic [7:0][7:0] bank_q;
  logic [2:0]      rd_lo_r;

  for (genvar k = 0; k < 8; k++) begin : g_bank
    logic [7:0]    mem [ROWS];
    logic [7:0]    q_r;
    logic [RW-1:0] rrow;
    logic [RW-1:0] wrow;
    logic [2:0]    wsel;

    // bytes below the start offset live one row up
    always_comb begin
      rrow = RW'(rd_addr[PW-1:3] + (PW-3)'((3'(k) < rd_addr[2:0]) ? 1 : 0));
      wrow = RW'(wr_addr[PW-1:3] + (PW-3)'((3'(k) < wr_addr[2:0]) ? 1 : 0));
      wsel = 3'(3'(k) - wr_addr[2:0]);
    end

    always_ff @(posedge clk) begin
      if (clr_en) begin
        mem[clr_row] <= 8'h00;
      end else if (wr_en) begin
        mem[wrow] <= wr_data[{wsel, 3'b000} +: 8];
      end
      if (rd_en) begin
        q_r <= mem[rrow];
      end
    end

    assign bank_q[k] = q_r;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_lo_r <= rd_addr[2:0];
    end
  end

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      rd_data[8*j +: 8] = bank_q[3'(rd_lo_r + 3'(j))];
    end
  end

endmodule

// ===== sv/sbe_unit.sv =====
// ----------------------------------------------------------------------------
// sbe_unit: multi-cycle arithmetic unit
// 64-bit multiply from 32x32 partial products, restoring divide/modulo,
// and unsigned integer to binary64 conversion with bit-serial normalize.
// ----------------------------------------------------------------------------
module sbe_unit import sbe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  unit_t             op,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic              done,
  output logic [WORD_W-1:0] result
);

  typedef enum logic [2:0] {U_IDLE, U_MUL, U_DIV, U_NORM, U_RND} ust_t;

  ust_t              st_r;
  logic              done_r;
  logic [5:0]        cnt_r;
  logic              want_mod_r;
  logic [WORD_W-1:0] x_r, y_r, acc_r, prod_r, rem_r, res_r;

  logic [31:0] ma, mb;
  logic [63:0] prod_c;
  logic [64:0] r_sh, diff;
  logic [63:0] rem_n, q_n;
  logic [53:0] mant, mant_r;
  logic [10:0] rbits, expo;
  logic        rinc;
  logic [63:0] fp_c;

  always_comb begin
    unique case (cnt_r[1:0])
      2'd0:    begin ma = x_r[31:0];  mb = y_r[31:0];  end
      2'd1:    begin ma = x_r[31:0];  mb = y_r[63:32]; end
      default: begin ma = x_r[63:32]; mb = y_r[31:0];  end
    endcase
    prod_c = ma * mb;

    r_sh  = {rem_r, x_r[63]};
    diff  = r_sh - {1'b0, y_r};
    rem_n = diff[64] ? r_sh[63:0] : diff[63:0];
    q_n   = {x_r[62:0], ~diff[64]};

    // round to nearest even on the 11 bits below the 53-bit mantissa
    mant   = {1'b0, x_r[63:11]};
    rbits  = x_r[10:0];
    rinc   = (rbits > 11'h400) || ((rbits == 11'h400) && x_r[11]);
    mant_r = mant + 54'(rinc);
    expo   = 11'd1086 - {5'b0, cnt_r};
    if (mant_r[53]) begin
      fp_c = {1'b0, 11'(expo + 11'd1), mant_r[52:1]};
    end else begin
      fp_c = {1'b0, expo, mant_r[51:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= U_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        U_IDLE: begin
          if (start) begin
            x_r   <= a;
            y_r   <= b;
            acc_r <= '0;
            rem_r <= '0;
            cnt_r <= '0;
            want_mod_r <= (op == UNIT_MOD);
            unique case (op)
              UNIT_MUL:            st_r <= U_MUL;
              UNIT_DIV, UNIT_MOD:  st_r <= U_DIV;
              default: begin
                if (a == '0) begin
                  res_r  <= '0;
                  done_r <= 1'b1;
                end else begin
                  st_r <= U_NORM;
                end
              end
            endcase
          end
        end
        U_MUL: begin
          prod_r <= prod_c;
          cnt_r  <= cnt_r + 6'd1;
          if (cnt_r == 6'd1) begin
            acc_r <= acc_r + prod_r;
          end else if (cnt_r == 6'd2) begin
            acc_r <= acc_r + {prod_r[31:0], 32'b0};
          end else if (cnt_r == 6'd3) begin
            res_r  <= acc_r + {prod_r[31:0], 32'b0};
            done_r <= 1'b1;
            st_r   <= U_IDLE;
          end
        end
        U_DIV: begin
          x_r   <= q_n;
          rem_r <= rem_n;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            res_r  <= want_mod_r ? rem_n : q_n;
            done_r <= 1'b1;
            st_r   <= U_IDLE;
          end
        end
        U_NORM: begin
          if (x_r[63]) begin
            st_r <= U_RND;
          end else begin
            x_r   <= {x_r[62:0], 1'b0};
            cnt_r <= cnt_r + 6'd1;
          end
        end
        U_RND: begin
          res_r  <= fp_c;
          done_r <= 1'b1;
          st_r   <= U_IDLE;
        end
        default: st_r <= U_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

// ===== sv/sbe_dp.sv =====
// ----------------------------------------------------------------------------
// sbe_dp: executor datapath
// Architectural registers, stack memory, ALU, conversions and result register.
// ----------------------------------------------------------------------------
module sbe_dp import sbe_pkg::*; #(
  parameter  int STACK_BYTES = STACK_BYTES_DEF,
  localparam int PW   = $clog2(STACK_BYTES + 1),
  localparam int ROWS = (STACK_BYTES + 7) / 8,
  localparam int RW   = $clog2(ROWS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic [IMM_W-1:0]  imm_in,
  output sts_t              sts,
  output logic [IMM_W-1:0]  out_next_ip,
  output logic              out_halted,
  output logic [WORD_W-1:0] out_exit_value,
  output logic [FLT_W-1:0]  out_fault
);

  logic [IMM_W-1:0]  ip_r, imm_r;
  logic [PW-1:0]     sp_r, bp_r;
  logic              halt_r;
  fault_t            fault_r;
  logic [WORD_W-1:0] exit_r, a_r, b_r, c_r;
  logic [RW-1:0]     clr_row_r;

  logic [IMM_W-1:0]  onip_r;
  logic              ohalt_r;
  logic [WORD_W-1:0] oexit_r;
  logic [FLT_W-1:0]  ofault_r;

  logic [PW-1:0]     base, ret_adr, rd_addr, wr_addr;
  logic [49:0]       ld_sum;
  logic [WORD_W-1:0] rd_data, wr_data, alu_res, unit_res;
  logic              unit_done;

  function automatic logic [63:0] f64_to_u64(input logic [63:0] v);
    logic [10:0] e;
    logic [10:0] u;
    logic [63:0] m;
    e = v[62:52];
    u = e - 11'd1023;
    m = {11'b0, 1'b1, v[51:0]};
    if (e == 11'h7FF) begin
      return ((v[51:0] != '0) || v[63]) ? 64'd0 : '1;
    end else if (v[63] || (e < 11'd1023)) begin
      return 64'd0;
    end else if (u >= 11'd64) begin
      return '1;
    end else if (u >= 11'd52) begin
      return m << (u - 11'd52);
    end else begin
      return m >> (11'd52 - u);
    end
  endfunction

  function automatic logic [PW-1:0] adr_of(input adr_t s, input logic [PW-1:0] sp,
                                           input logic [PW-1:0] bp,
                                           input logic [PW-1:0] ld,
                                           input logic [PW-1:0] rt);
    unique case (s)
      ADR_SP:    return sp;
      ADR_SP8:   return sp + PW'(8);
      ADR_SPM8:  return sp - PW'(8);
      ADR_SPM16: return sp - PW'(16);
      ADR_BPM8:  return bp - PW'(8);
      ADR_BPM16: return bp - PW'(16);
      ADR_LOAD:  return ld;
      default:   return rt;
    endcase
  endfunction

  always_comb begin
    base    = bp_r - PW'(16);
    ret_adr = base - imm_r[PW-1:0];
    ld_sum  = {{2{imm_r[47]}}, imm_r} + (cmd.frame_rel ? 50'(bp_r) : 50'd0);
    rd_addr = adr_of(cmd.rd_adr, sp_r, bp_r, ld_sum[PW-1:0], ret_adr);
    wr_addr = adr_of(cmd.wr_adr, sp_r, bp_r, ld_sum[PW-1:0], ret_adr);

    // a is the popped top, b the word below it
    unique case (cmd.alu)
      ALU_ADD: alu_res = a_r + b_r;
      ALU_SUB: alu_res = a_r - b_r;
      ALU_EQ:  alu_res = {63'b0, a_r == b_r};
      ALU_NE:  alu_res = {63'b0, a_r != b_r};
      ALU_LT:  alu_res = {63'b0, a_r < b_r};
      ALU_LE:  alu_res = {63'b0, a_r <= b_r};
      ALU_GT:  alu_res = {63'b0, a_r > b_r};
      default: alu_res = {63'b0, a_r >= b_r};
    endcase

    unique case (cmd.wr_dat)
      WD_IP:   wr_data = {16'b0, ip_r};
      WD_BP:   wr_data = WORD_W'(bp_r);
      WD_IMM:  wr_data = {16'b0, imm_r};
      WD_A:    wr_data = a_r;
      WD_ALU:  wr_data = alu_res;
      WD_UNIT: wr_data = unit_res;
      default: wr_data = f64_to_u64(a_r);
    endcase

    sts.clr_last    = (clr_row_r == RW'(ROWS - 1));
    sts.halted      = halt_r;
    sts.sp_lt8      = (sp_r < PW'(8));
    sts.sp_lt16     = (sp_r < PW'(16));
    sts.room8       = (sp_r <= PW'(STACK_BYTES - 8));
    sts.room16      = (sp_r <= PW'(STACK_BYTES - 16));
    sts.bp_lt16     = (bp_r < PW'(16));
    sts.ld_bad      = ld_sum[49] || (ld_sum > 50'(STACK_BYTES - 8));
    sts.imm_gt_base = (imm_r > IMM_W'(base));
    sts.nbp_big     = (b_r > WORD_W'(STACK_BYTES));
    sts.a_nz        = (a_r != '0);
    sts.b_zero      = (b_r == '0);
    sts.unit_done   = unit_done;
  end

  sbe_stack #(.STACK_BYTES(STACK_BYTES)) u_stack (
    .clk     (clk),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .clr_en  (cmd.clr),
    .clr_row (clr_row_r),
    .rd_data (rd_data)
  );

  sbe_unit u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.unit_go),
    .op     (cmd.unit_op),
    .a      (a_r),
    .b      (b_r),
    .done   (unit_done),
    .result (unit_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ip_r      <= '0;
      sp_r      <= '0;
      bp_r      <= '0;
      halt_r    <= 1'b0;
      fault_r   <= FLT_NONE;
      exit_r    <= '1;
      clr_row_r <= '0;
    end else begin
      if (cmd.clr) begin
        clr_row_r <= clr_row_r + RW'(1);
      end
      unique case (cmd.sp_op)
        SP_INC8:  sp_r <= sp_r + PW'(8);
        SP_INC16: sp_r <= sp_r + PW'(16);
        SP_DEC8:  sp_r <= sp_r - PW'(8);
        SP_RET:   sp_r <= ret_adr + PW'(8);
        default:  sp_r <= sp_r;
      endcase
      unique case (cmd.bp_op)
        BP_CALL:    bp_r <= sp_r + PW'(16);
        BP_RESTORE: bp_r <= b_r[PW-1:0];
        default:    bp_r <= bp_r;
      endcase
      unique case (cmd.ip_op)
        IP_INC:  ip_r <= ip_r + IMM_W'(1);
        IP_IMM:  ip_r <= imm_r;
        IP_RET:  ip_r <= c_r[IMM_W-1:0] + IMM_W'(1);
        default: ip_r <= ip_r;
      endcase
      if (cmd.fault != FLT_NONE) begin
        fault_r <= cmd.fault;
        halt_r  <= 1'b1;
      end
      if (cmd.halt_set) begin
        halt_r <= 1'b1;
      end
      if (cmd.exit_set) begin
        exit_r <= a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take)  imm_r <= imm_in;
    if (cmd.cap_a) a_r   <= rd_data;
    if (cmd.cap_b) b_r   <= rd_data;
    if (cmd.cap_c) c_r   <= rd_data;
    if (cmd.out_load) begin
      onip_r   <= ip_r;
      ohalt_r  <= halt_r;
      oexit_r  <= exit_r;
      ofault_r <= fault_r;
    end
  end

  assign out_next_ip    = onip_r;
  assign out_halted     = ohalt_r;
  assign out_exit_value = oexit_r;
  assign out_fault      = ofault_r;

endmodule

// ===== sv/sbe_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbe_ctrl: executor controller
// Sequences memory reads, writes, checks and commits for each instruction.
// ----------------------------------------------------------------------------
module sbe_ctrl import sbe_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] op,
  input  logic            out_ready,
  input  sts_t            sts,
  output logic            in_ready,
  output logic            out_valid,
  output cmd_t            cmd
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DEC, S_CALL2, S_LDCAP, S_LDWR, S_BRCAP, S_BRDO,
    S_BINB, S_BINCAP, S_BINEX, S_BINWAIT, S_CVCAP, S_CVEX, S_CVWAIT,
    S_EXCAP, S_EXDO, S_RTB, S_RTC, S_RTCAP, S_RTDO, S_OUT
  } state_t;

  state_t          state_r, state_nxt;
  logic [OP_W-1:0] op_r;
  logic            out_valid_r;
  logic            out_free;

  function automatic alu_t alu_of(input logic [OP_W-1:0] o);
    unique case (o)
      OP_SUB:  return ALU_SUB;
      OP_EQ:   return ALU_EQ;
      OP_NE:   return ALU_NE;
      OP_LT:   return ALU_LT;
      OP_LE:   return ALU_LE;
      OP_GT:   return ALU_GT;
      OP_GE:   return ALU_GE;
      default: return ALU_ADD;
    endcase
  endfunction

  function automatic unit_t unit_of(input logic [OP_W-1:0] o);
    unique case (o)
      OP_MUL:  return UNIT_MUL;
      OP_DIV:  return UNIT_DIV;
      OP_MOD:  return UNIT_MOD;
      default: return UNIT_ITOF;
    endcase
  endfunction

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    cmd           = '0;
    cmd.alu       = alu_of(op_r);
    cmd.unit_op   = unit_of(op_r);
    cmd.frame_rel = (op_r == OP_FLOAD);
    state_nxt     = state_r;

    unique case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_OUT;
        if (!sts.halted) begin
          unique case (op_r)
            OP_CALL: begin
              if (!sts.room16) begin
                cmd.fault = FLT_OVER;
              end else begin
                cmd.wr_en  = 1'b1;
                cmd.wr_adr = ADR_SP;
                cmd.wr_dat = WD_IP;
                state_nxt  = S_CALL2;
              end
            end
            OP_RET: begin
              if (sts.sp_lt8 || sts.bp_lt16) begin
                cmd.fault = FLT_UNDER;
              end else begin
                cmd.rd_en  = 1'b1;
                cmd.rd_adr = ADR_SPM8;
                state_nxt  = S_RTB;
              end
            end
            OP_PUSH: begin
              if (!sts.room8) begin
                cmd.fault = FLT_OVER;
              end else begin
                cmd.wr_en  = 1'b1;
                cmd.wr_adr = ADR_SP;
                cmd.wr_dat = WD_IMM;
                cmd.sp_op  = SP_INC8;
                cmd.ip_op  = IP_INC;
              end
            end
            OP_LOAD, OP_FLOAD: begin
              if (sts.ld_bad) begin
                cmd.fault = FLT_RANGE;
              end else if (!sts.room8) begin
                cmd.fault = FLT_OVER;
              end else begin
                cmd.rd_en  = 1'b1;
                cmd.rd_adr = ADR_LOAD;
                state_nxt  = S_LDCAP;
              end
            end
            OP_JUMP: cmd.ip_op = IP_IMM;
            OP_BRT, OP_BRF, OP_ITOF, OP_FTOI, OP_EXIT: begin
              if (sts.sp_lt8) begin
                cmd.fault = FLT_UNDER;
              end else begin
                cmd.rd_en  = 1'b1;
                cmd.rd_adr = ADR_SPM8;
                if (op_r == OP_EXIT) begin
                  state_nxt = S_EXCAP;
                end else if (op_r == OP_ITOF || op_r == OP_FTOI) begin
                  state_nxt = S_CVCAP;
                end else begin
                  state_nxt = S_BRCAP;
                end
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_NE,
            OP_LT, OP_LE, OP_GT, OP_GE: begin
              if (sts.sp_lt16) begin
                cmd.fault = FLT_UNDER;
              end else begin
                cmd.rd_en  = 1'b1;
                cmd.rd_adr = ADR_SPM8;
                state_nxt  = S_BINB;
              end
            end
            default: cmd.ip_op = IP_INC;
          endcase
        end
      end
      S_CALL2: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_adr = ADR_SP8;
        cmd.wr_dat = WD_BP;
        cmd.sp_op  = SP_INC16;
        cmd.bp_op  = BP_CALL;
        cmd.ip_op  = IP_IMM;
        state_nxt  = S_OUT;
      end
      S_LDCAP: begin
        cmd.cap_a = 1'b1;
        state_nxt = S_LDWR;
      end
      S_LDWR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_adr = ADR_SP;
        cmd.wr_dat = WD_A;
        cmd.sp_op  = SP_INC8;
        cmd.ip_op  = IP_INC;
        state_nxt  = S_OUT;
      end
      S_BRCAP: begin
        cmd.cap_a = 1'b1;
        state_nxt = S_BRDO;
      end
      S_BRDO: begin
        cmd.sp_op = SP_DEC8;
        cmd.ip_op = ((op_r == OP_BRT) == sts.a_nz) ? IP_IMM : IP_INC;
        state_nxt = S_OUT;
      end
      S_BINB: begin
        cmd.cap_a  = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_adr = ADR_SPM16;
        state_nxt  = S_BINCAP;
      end
      S_BINCAP: begin
        cmd.cap_b = 1'b1;
        state_nxt = S_BINEX;
      end
      S_BINEX: begin
        if ((op_r == OP_DIV || op_r == OP_MOD) && sts.b_zero) begin
          cmd.fault = FLT_DIV0;
          state_nxt = S_OUT;
        end else if (op_r == OP_MUL || op_r == OP_DIV || op_r == OP_MOD) begin
          cmd.unit_go = 1'b1;
          state_nxt   = S_BINWAIT;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_adr = ADR_SPM16;
          cmd.wr_dat = WD_ALU;
          cmd.sp_op  = SP_DEC8;
          cmd.ip_op  = IP_INC;
          state_nxt  = S_OUT;
        end
      end
      S_BINWAIT: begin
        if (sts.unit_done) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_adr = ADR_SPM16;
          cmd.wr_dat = WD_UNIT;
          cmd.sp_op  = SP_DEC8;
          cmd.ip_op  = IP_INC;
          state_nxt  = S_OUT;
        end
      end
      S_CVCAP: begin
        cmd.cap_a = 1'b1;
        state_nxt = S_CVEX;
      end
      S_CVEX: begin
        if (op_r == OP_ITOF) begin
          cmd.unit_go = 1'b1;
          state_nxt   = S_CVWAIT;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_adr = ADR_SPM8;
          cmd.wr_dat = WD_FTOI;
          cmd.ip_op  = IP_INC;
          state_nxt  = S_OUT;
        end
      end
      S_CVWAIT: begin
        if (sts.unit_done) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_adr = ADR_SPM8;
          cmd.wr_dat = WD_UNIT;
          cmd.ip_op  = IP_INC;
          state_nxt  = S_OUT;
        end
      end
      S_EXCAP: begin
        cmd.cap_a = 1'b1;
        state_nxt = S_EXDO;
      end
      S_EXDO: begin
        cmd.exit_set = 1'b1;
        cmd.halt_set = 1'b1;
        cmd.sp_op    = SP_DEC8;
        cmd.ip_op    = IP_INC;
        state_nxt    = S_OUT;
      end
      S_RTB: begin
        cmd.cap_a  = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_adr = ADR_BPM8;
        state_nxt  = S_RTC;
      end
      S_RTC: begin
        cmd.cap_b  = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_adr = ADR_BPM16;
        state_nxt  = S_RTCAP;
      end
      S_RTCAP: begin
        cmd.cap_c = 1'b1;
        state_nxt = S_RTDO;
      end
      S_RTDO: begin
        state_nxt = S_OUT;
        if (sts.imm_gt_base) begin
          cmd.fault = FLT_UNDER;
        end else if (sts.nbp_big) begin
          cmd.fault = FLT_OVER;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_adr = ADR_RET;
          cmd.wr_dat = WD_A;
          cmd.sp_op  = SP_RET;
          cmd.bp_op  = BP_RESTORE;
          cmd.ip_op  = IP_RET;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) op_r <= op;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== sv/stack_bytecode_executor.sv =====
// ----------------------------------------------------------------------------
// stack_bytecode_executor: one stack-machine instruction per transaction
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): one instruction per transaction, opcode and
//   48-bit immediate. Output stream (out_*): one status transaction per
//   instruction with next ip, halted flag, exit value and fault code.
//   in_tready is high only while the controller waits for an instruction.
//   Each instruction steps through the controller states for its opcode.
//   Nop/jump/push, and any instruction once halted, go straight to the
//   output state; mul (four-step 32x32 multiply), div/mod (one quotient
//   bit per cycle) and itof (one-bit-per-cycle normalize) wait on the
//   iterative unit. The stack port (one word per cycle) and these
//   iterative units set how long each instruction takes. A new one is
//   accepted only after the previous one has left the output state.
//   Reset: rst_n low, synchronous. After release the stack is zeroed by a
//   clearing pass over its (STACK_BYTES+7)/8 rows (512 at the default size);
//   in_tready stays low until it ends.
//   Stall: a finished result sits in the output register; the next
//   instruction is accepted and executed meanwhile, and only its own
//   result waits for the register to drain.
//   Once halted (exit or fault) each further transaction is answered with
//   the unchanged state.
// ----------------------------------------------------------------------------
module stack_bytecode_executor import sbe_pkg::*; #(
  parameter int STACK_BYTES = STACK_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // [15:0] operation, [63:16] immediate
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata   // [47:0] next_ip, [48] halted,
                                   // [112:49] exit_value, [115:113] fault, zero pad
);

  cmd_t              cmd;
  sts_t              sts;
  logic [IMM_W-1:0]  next_ip;
  logic              halted;
  logic [WORD_W-1:0] exit_value;
  logic [FLT_W-1:0]  fault;

  // controller: instruction sequencing and output handshake
  sbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .op        (in_tdata[15:0]),
    .out_ready (out_tready),
    .sts       (sts),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .cmd       (cmd)
  );

  // datapath: registers, stack memory, arithmetic, result register
  sbe_dp #(.STACK_BYTES(STACK_BYTES)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .imm_in         (in_tdata[63:16]),
    .sts            (sts),
    .out_next_ip    (next_ip),
    .out_halted     (halted),
    .out_exit_value (exit_value),
    .out_fault      (fault)
  );

  assign out_tdata = {4'b0, fault, exit_value, halted, next_ip};

endmodule

// ===== sv/sbe_checker.sv =====
// ----------------------------------------------------------------------------
// sbe_checker: port-level checks for the executor
// Watches the stream ports; attached to the top level by bind.
// ----------------------------------------------------------------------------
module sbe_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [63:0]  in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [119:0] out_tdata
);

  logic [1:0] pend_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input taken during clearing pass");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 2'd0)
    else $error("result with no instruction outstanding");

  a_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("second instruction taken back to back");

endmodule

bind stack_bytecode_executor sbe_checker u_chk (.*);
